// ===== sv/ll1tp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, grammar tables and engine states for the LL(1) table parser.
// No dependencies; every other file imports this package.
package ll1tp_pkg;

  localparam int unsigned KIND_W          = 3;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned EVK_W           = 3;
  localparam int unsigned PROD_W          = 4;
  localparam int unsigned SYM_W           = 4;
  localparam int unsigned NT_COUNT        = 6;
  localparam int unsigned KIND_COUNT      = 6;
  localparam int unsigned PROD_COUNT      = 9;
  localparam int unsigned RHS_MAX         = 4;
  localparam int unsigned RHS_LEN_W       = 3;
  localparam int unsigned MAX_RESULTS     = 8;
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS);
  localparam int unsigned STACK_DEPTH_DEF = 64;

  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [RHS_LEN_W-1:0] rhs_len_t;

  // Symbol encoding: nonterminals first, then terminals (token kind + base), then marker.
  localparam sym_t SYM_START     = 4'd0;
  localparam sym_t SYM_TERM_BASE = 4'd6;
  localparam sym_t SYM_LAST_TERM = 4'd11;
  localparam sym_t SYM_MARK      = 4'd12;
  localparam prod_t NO_RULE      = 4'd15;

  typedef enum logic [EVK_W-1:0] {
    EV_PROD   = 3'd0,
    EV_MARK   = 3'd1,
    EV_MATCH  = 3'd2,
    EV_ACCEPT = 3'd3,
    EV_ERROR  = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_PUSH
  } eng_state_t;

  // Prediction table, row = nonterminal, column = token kind.
  localparam prod_t [0:NT_COUNT-1][0:KIND_COUNT-1] PREDICT_TBL = '{
    '{4'd0,    NO_RULE, NO_RULE, NO_RULE, 4'd0,    NO_RULE},
    '{4'd1,    NO_RULE, NO_RULE, NO_RULE, 4'd1,    NO_RULE},
    '{NO_RULE, 4'd3,    NO_RULE, 4'd2,    NO_RULE, 4'd3   },
    '{4'd4,    NO_RULE, NO_RULE, NO_RULE, 4'd4,    NO_RULE},
    '{NO_RULE, 4'd6,    4'd5,    4'd6,    NO_RULE, 4'd6   },
    '{4'd7,    NO_RULE, NO_RULE, NO_RULE, 4'd8,    NO_RULE}
  };

  localparam rhs_len_t [0:PROD_COUNT-1] RHS_LEN_TBL = '{
    3'd2, 3'd2, 3'd4, 3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1
  };

  // Right-hand sides in push order: the last symbol ends on top.
  localparam sym_t [0:PROD_COUNT-1][0:RHS_MAX-1] RHS_SYM_TBL = '{
    '{4'd11, 4'd1,  4'd0, 4'd0},
    '{4'd2,  4'd3,  4'd0, 4'd0},
    '{4'd2,  4'd12, 4'd3, 4'd9},
    '{4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd4,  4'd5,  4'd0, 4'd0},
    '{4'd4,  4'd5,  4'd8, 4'd0},
    '{4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd7,  4'd1,  4'd6, 4'd0},
    '{4'd10, 4'd0,  4'd0, 4'd0}
  };

  // Classified token as it waits between front and engine.
  typedef struct packed {
    logic                      term_ok;
    sym_t                      term_sym;
    prod_t [NT_COUNT-1:0]      pred;
    logic [VALUE_W-1:0]        value;
  } tok_item_t;

endpackage

// ===== sv/ll1tp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tokens in and parse events out.
// Depends on ll1tp_pkg for field widths.
interface ll1tp_token_if import ll1tp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [VALUE_W-1:0] token_value;

  modport source (output valid, output token_kind, output token_value, input ready);
  modport sink   (input valid, input token_kind, input token_value, output ready);
endinterface

interface ll1tp_event_if import ll1tp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EVK_W-1:0]   event_kind;
  logic [PROD_W-1:0]  production;
  logic [VALUE_W-1:0] matched_value;
  logic               last;

  modport source (output valid, output event_kind, output production, output matched_value,
                  output last, input ready);
  modport sink   (input valid, input event_kind, input production, input matched_value,
                  input last, output ready);
endinterface

// ===== sv/ll1_table_parser.sv =====
`timescale 1ns / 1ps
// Top level of the LL(1) table parser: front end, token queue and stack engine.
// Depends on ll1tp_pkg, ll1tp_if, ll1tp_front, ll1tp_queue and ll1tp_engine.
//
// Usage: feed one token per transaction on tokens (token_kind, token_value).
// Each token yields one to eight event transactions on events: production
// applied, action marker, match, accept or error; last marks the final event
// of the token. After accept or error the stack restarts from the start symbol.
//
// Throughput: the engine works on one token at a time. Each expansion pushes its
// right-hand side one symbol at a time, and each action marker popped is a step of
// its own, up to the event budget. The registered read of the stack memory adds a
// fetch state to every step. A two-entry queue lets the front end take up to two
// tokens while the engine works.
//
// Reset: rst is synchronous, active high. The cycle after reset writes the start
// symbol into the stack bottom; tokens are taken from then on.
// Stall: events sit in an output register; while the receiver holds ready low
// the engine holds, and the queue fills and then drops tokens.ready.
module ll1_table_parser import ll1tp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ll1tp_token_if.sink   tokens,
  ll1tp_event_if.source events
);

  // front end to queue
  logic      fq_valid;
  logic      fq_ready;
  tok_item_t fq_item;

  // queue to engine
  logic      qe_valid;
  logic      qe_ready;
  tok_item_t qe_item;

  // classify each token: terminal symbol and its prediction column
  ll1tp_front u_front (
    .tokens     (tokens),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  // decouple acceptance from the stack work
  ll1tp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qe_valid),
    .pop_ready  (qe_ready),
    .pop_item   (qe_item)
  );

  // expand, pop and match against the symbol stack; drive the event register
  ll1tp_engine #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qe_valid),
    .q_ready (qe_ready),
    .q_item  (qe_item),
    .events  (events)
  );

endmodule

// ===== sv/ll1tp_front.sv =====
`timescale 1ns / 1ps
// Front end: takes tokens and looks up their prediction column ahead of the engine.
// Depends on ll1tp_pkg and ll1tp_token_if.
module ll1tp_front import ll1tp_pkg::*; (
  ll1tp_token_if.sink tokens,
  output logic        push_valid,
  input  logic        push_ready,
  output tok_item_t   push_item
);

  assign push_valid   = tokens.valid;
  assign tokens.ready = push_ready;

  always_comb begin
    push_item.term_ok  = (tokens.token_kind < KIND_W'(KIND_COUNT));
    push_item.term_sym = SYM_W'(tokens.token_kind) + SYM_TERM_BASE;
    push_item.value    = tokens.token_value;
    for (int i = 0; i < NT_COUNT; i++) begin
      // unknown kinds predict nothing
      push_item.pred[i] = push_item.term_ok ? PREDICT_TBL[i][tokens.token_kind] : NO_RULE;
    end
  end

endmodule

// ===== sv/ll1tp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified tokens between the front end and the engine.
// Depends on ll1tp_pkg.
module ll1tp_queue import ll1tp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  tok_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output tok_item_t pop_item
);

  tok_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== sv/ll1tp_engine.sv =====
`timescale 1ns / 1ps
// Back end: runs the symbol stack for one token at a time and emits parse events.
// Depends on ll1tp_pkg and ll1tp_event_if.
module ll1tp_engine import ll1tp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  tok_item_t     q_item,
  ll1tp_event_if.source events
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW:0] DEPTH_X = (SPW + 1)'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_RESULTS - 1);

  sym_t stack_mem [STACK_DEPTH];
  sym_t top_sym;

  eng_state_t       state, state_next;
  logic [SPW-1:0]   sp, sp_next;
  logic [CNT_W-1:0] n, n_next;
  prod_t            prod, prod_next;
  logic [1:0]       push_idx, push_idx_next;
  tok_item_t        cur;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  sym_t             mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic               ev_valid;
  event_kind_t        ev_kind, ev_kind_next;
  prod_t              ev_prod, ev_prod_next;
  logic [VALUE_W-1:0] ev_val, ev_val_next;
  logic               ev_last, ev_last_next;
  logic               ev_load;
  logic               out_free;

  logic             q_take;
  logic             do_restart;
  logic [SPW-1:0]   sp_dec;
  logic             top_is_nt;
  logic [2:0]       nt_idx;
  prod_t            pred_p;
  rhs_len_t         pred_len;
  rhs_len_t         push_len;
  logic             overflow;

  assign mem_raddr = AW'(sp - SPW'(1));
  assign sp_dec    = sp - SPW'(1);
  assign top_is_nt = (top_sym < SYM_TERM_BASE);
  assign nt_idx    = top_is_nt ? top_sym[2:0] : 3'd0;
  assign pred_p    = cur.pred[nt_idx];
  assign pred_len  = (pred_p == NO_RULE) ? '0 : RHS_LEN_TBL[pred_p];
  assign push_len  = RHS_LEN_TBL[prod];
  assign overflow  = ({1'b0, sp} - (SPW + 1)'(1) + (SPW + 1)'(pred_len)) > DEPTH_X;
  assign out_free  = !ev_valid || events.ready;
  assign q_take    = q_valid && q_ready;

  always_comb begin
    state_next    = state;
    sp_next       = sp;
    n_next        = n;
    prod_next     = prod;
    push_idx_next = push_idx;
    q_ready       = 1'b0;
    do_restart    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = SYM_START;
    ev_load       = 1'b0;
    ev_kind_next  = EV_ERROR;
    ev_prod_next  = '0;
    ev_val_next   = '0;
    ev_last_next  = 1'b0;
    unique case (state)
      ST_INIT: begin
        do_restart = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          n_next     = '0;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          ev_load = 1'b1;
          priority if (n == LAST_SLOT) begin
            ev_last_next = 1'b1;
            do_restart   = 1'b1;
            state_next   = ST_IDLE;
          end else if (top_is_nt) begin
            if (pred_p == NO_RULE || overflow) begin
              ev_last_next = 1'b1;
              do_restart   = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              ev_kind_next  = EV_PROD;
              ev_prod_next  = pred_p;
              n_next        = n + CNT_W'(1);
              prod_next     = pred_p;
              push_idx_next = '0;
              sp_next       = sp_dec;
              if (pred_len == '0) begin
                do_restart = (sp_dec == '0);
                state_next = ST_FETCH;
              end else begin
                state_next = ST_PUSH;
              end
            end
          end else if (top_sym > SYM_LAST_TERM) begin
            ev_kind_next = EV_MARK;
            n_next       = n + CNT_W'(1);
            sp_next      = sp_dec;
            do_restart   = (sp_dec == '0);
            state_next   = ST_FETCH;
          end else if (cur.term_ok && top_sym == cur.term_sym) begin
            ev_last_next = 1'b1;
            ev_val_next  = cur.value;
            sp_next      = sp_dec;
            state_next   = ST_IDLE;
            if (sp_dec == '0) begin
              ev_kind_next = EV_ACCEPT;
              do_restart   = 1'b1;
            end else begin
              ev_kind_next = EV_MATCH;
            end
          end else begin
            ev_last_next = 1'b1;
            do_restart   = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_PUSH: begin
        mem_we        = 1'b1;
        mem_waddr     = AW'(sp);
        mem_wdata     = RHS_SYM_TBL[prod][push_idx];
        sp_next       = sp + SPW'(1);
        push_idx_next = push_idx + 2'd1;
        if ({1'b0, push_idx} == push_len - rhs_len_t'(1)) state_next = ST_FETCH;
      end
      default: state_next = ST_INIT;
    endcase
    // fresh stack: start symbol alone at the bottom
    if (do_restart) begin
      sp_next   = SPW'(1);
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = SYM_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      sp       <= SPW'(1);
      n        <= '0;
      push_idx <= '0;
      ev_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sp       <= sp_next;
      n        <= n_next;
      push_idx <= push_idx_next;
      if (ev_load)           ev_valid <= 1'b1;
      else if (events.ready) ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (q_take) cur <= q_item;
    if (ev_load) begin
      ev_kind <= ev_kind_next;
      ev_prod <= ev_prod_next;
      ev_val  <= ev_val_next;
      ev_last <= ev_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    top_sym <= stack_mem[mem_raddr];
  end

  assign events.valid         = ev_valid;
  assign events.event_kind    = ev_kind;
  assign events.production    = ev_prod;
  assign events.matched_value = ev_val;
  assign events.last          = ev_last;

`ifndef NO_ASSERTIONS
  // while pushing, the pointer starts from the popped slot and may sit at zero
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_PUSH |-> sp != '0 && sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUSH |-> sp < SPW'(STACK_DEPTH) && {1'b0, push_idx} < push_len)
    else $error("push beyond stack or right-hand side");

  a_last_ends_token: assert property (@(posedge clk) disable iff (rst)
    ev_load && ev_last_next |=> state == ST_IDLE)
    else $error("final event did not end the token");

  a_budget: assert property (@(posedge clk) disable iff (rst)
    ev_load && !ev_last_next |=> n != '0 && n <= LAST_SLOT)
    else $error("event count out of step");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == ST_IDLE)
    else $error("token taken while engine busy");
`endif

endmodule

// ===== sim/tb_ll1_table_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ll1_table_parser: a directed token table, then random
// expression streams, checked against a cycle-free parser predictor or, for typed rows, their own event.
// Depends on ll1tp_pkg, ll1tp_if and the parser RTL.
module tb_ll1_table_parser;
  import ll1tp_pkg::*;

  localparam int unsigned STACK_CAP     = 64;
  localparam int unsigned MAX_EVENTS    = 8;
  localparam int unsigned RANDOM_TOKENS = 400;
  localparam int unsigned HOLD_AFTER    = 300;   // events seen before the long stall
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 40;
  // Slowest token: 8 events, each behind a random receiver stall, plus the long
  // hold-off; the limit leaves plenty of margin over that.
  localparam int unsigned IDLE_LIMIT    = 3000;

  typedef logic [KIND_W-1:0]  tkind_t;
  typedef logic [VALUE_W-1:0] tvalue_t;
  typedef logic [3:0]         gsym_t;

  // Token kinds as they appear on the input channel.
  localparam tkind_t TK_LPAREN = 3'd0;
  localparam tkind_t TK_RPAREN = 3'd1;
  localparam tkind_t TK_STAR   = 3'd2;
  localparam tkind_t TK_PLUS   = 3'd3;
  localparam tkind_t TK_DIGIT  = 3'd4;
  localparam tkind_t TK_END    = 3'd5;
  localparam tkind_t TK_BAD6   = 3'd6;
  localparam tkind_t TK_BAD7   = 3'd7;
  localparam int unsigned TK_VALID_COUNT = 6;

  // Grammar symbols: nonterminals 0..5, terminals are token kind + 6, 12 is the add marker.
  localparam gsym_t GS_START   = 4'd0;
  localparam gsym_t GS_TERM_LO = 4'd6;
  localparam gsym_t GS_TERM_HI = 4'd11;
  localparam prod_t NO_PICK    = 4'd15;

  // Which production to apply, row = nonterminal, column = token kind.
  localparam prod_t [0:5][0:5] PICK_TBL = '{
    '{4'd0,    NO_PICK, NO_PICK, NO_PICK, 4'd0,    NO_PICK},
    '{4'd1,    NO_PICK, NO_PICK, NO_PICK, 4'd1,    NO_PICK},
    '{NO_PICK, 4'd3,    NO_PICK, 4'd2,    NO_PICK, 4'd3   },
    '{4'd4,    NO_PICK, NO_PICK, NO_PICK, 4'd4,    NO_PICK},
    '{NO_PICK, 4'd6,    4'd5,    4'd6,    NO_PICK, 4'd6   },
    '{4'd7,    NO_PICK, NO_PICK, NO_PICK, 4'd8,    NO_PICK}
  };

  // Production bodies in push order; the last symbol pushed ends on top.
  localparam logic [0:8][2:0] BODY_LEN = '{
    3'd2, 3'd2, 3'd4, 3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1
  };
  localparam logic [0:8][0:3][3:0] BODY_SYM = '{
    '{4'd11, 4'd1,  4'd0, 4'd0},
    '{4'd2,  4'd3,  4'd0, 4'd0},
    '{4'd2,  4'd12, 4'd3, 4'd9},
    '{4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd4,  4'd5,  4'd0, 4'd0},
    '{4'd4,  4'd5,  4'd8, 4'd0},
    '{4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd7,  4'd1,  4'd6, 4'd0},
    '{4'd10, 4'd0,  4'd0, 4'd0}
  };

  typedef struct packed {
    event_kind_t kind;
    prod_t       prod;
    tvalue_t     value;
    logic        last;
  } parse_event_t;

  // One token of the script; typed rows carry their single expected event.
  typedef struct packed {
    tkind_t       kind;
    tvalue_t      value;
    logic         typed;
    parse_event_t want;
  } token_row_t;

  typedef struct packed {
    tkind_t      kind;
    tvalue_t     value;
    logic        typed;
    event_kind_t want_kind;
    prod_t       want_prod;
    tvalue_t     want_value;
  } directed_row_t;

  // Directed tokens. Rows marked typed start from a fresh stack and give exactly one
  // error event with zeroed fields; the rest are checked against the predictor.
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam directed_row_t [0:DIRECTED_ROWS-1] DIRECTED_TBL = '{
    // no rule for the start symbol: every kind but '(' and digit is rejected at once
    '{TK_RPAREN, 16'hFFFF, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    '{TK_STAR,   16'h0000, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    '{TK_PLUS,   16'h1234, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    '{TK_END,    16'hFFFF, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    // unknown kinds have no table entry
    '{TK_BAD6,   16'h5A5A, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    '{TK_BAD7,   16'hFFFF, 1'b1, EV_ERROR, 4'd0, 16'h0000},
    // 65535 + (0 * 21845) * 1 $ : every production, marker, accept
    '{TK_DIGIT,  16'hFFFF, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_PLUS,   16'h0001, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_LPAREN, 16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_DIGIT,  16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_STAR,   16'hAAAA, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_DIGIT,  16'h5555, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_RPAREN, 16'h8000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_STAR,   16'h7FFF, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_DIGIT,  16'h0001, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_END,    16'hFFFF, 1'b0, EV_PROD,  4'd0, 16'h0000},
    // shortest sentence
    '{TK_DIGIT,  16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_END,    16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    // two digits in a row: no rule mid-sentence
    '{TK_DIGIT,  16'h1111, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_DIGIT,  16'h2222, 1'b0, EV_PROD,  4'd0, 16'h0000},
    // end of input against a pending ')': terminal mismatch after two expansions
    '{TK_LPAREN, 16'h3333, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_DIGIT,  16'h4444, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_END,    16'h5555, 1'b0, EV_PROD,  4'd0, 16'h0000},
    // unknown kind in the middle of a sentence
    '{TK_LPAREN, 16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000},
    '{TK_BAD7,   16'h0000, 1'b0, EV_PROD,  4'd0, 16'h0000}
  };

  typedef enum {SINK_OPEN, SINK_BUSY, SINK_CHOKED} sink_mode_t;

  logic clk;
  logic rst;

  ll1tp_token_if token_ch ();
  ll1tp_event_if event_ch ();

  ll1_table_parser #(.STACK_DEPTH(STACK_CAP)) uut (
    .clk    (clk),
    .rst    (rst),
    .tokens (token_ch),
    .events (event_ch)
  );

  // Predictor state: its own copy of the symbol stack.
  gsym_t       sym_stack [0:STACK_CAP-1];
  int unsigned stack_fill;

  parse_event_t token_events[$];     // events of the token being predicted
  parse_event_t expected_events[$];  // predicted events not yet seen on the output
  token_row_t   token_script[$];

  int          mangle_countdown = -1;
  int unsigned fail_count = 0;
  int unsigned events_checked = 0;
  int unsigned accept_count = 0;
  int unsigned error_count = 0;
  int unsigned mark_count = 0;
  int unsigned tokens_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop everything and restart from the start symbol.
  function automatic void restart_stack();
    sym_stack[0] = GS_START;
    stack_fill   = 1;
  endfunction

  function automatic void add_event(event_kind_t k, prod_t p, tvalue_t v);
    parse_event_t e;
    e.kind  = k;
    e.prod  = p;
    e.value = v;
    e.last  = 1'b0;
    token_events.push_back(e);
  endfunction

  // Expand, pop markers and match until the token is consumed or rejected.
  task automatic predict_parse_events(input tkind_t kind, input tvalue_t value);
    gsym_t       top;
    prod_t       pick;
    int unsigned body;
    int unsigned i;
    bit          done;
    token_events.delete();
    if (stack_fill == 0 || stack_fill > STACK_CAP) restart_stack();
    done = 1'b0;
    while (!done) begin
      if (token_events.size() >= MAX_EVENTS - 1) begin
        // out of event budget: the last slot goes to the error
        add_event(EV_ERROR, '0, '0);
        restart_stack();
        done = 1'b1;
      end else begin
        top = sym_stack[stack_fill-1];
        if (top < GS_TERM_LO) begin
          pick = (int'(kind) < TK_VALID_COUNT) ? PICK_TBL[top][kind] : NO_PICK;
          body = (pick == NO_PICK) ? 0 : int'(BODY_LEN[pick]);
          if (pick == NO_PICK || stack_fill - 1 + body > STACK_CAP) begin
            // syntax error, or the body would overflow the stack
            add_event(EV_ERROR, '0, '0);
            restart_stack();
            done = 1'b1;
          end else begin
            stack_fill--;
            for (i = 0; i < body; i++) begin
              sym_stack[stack_fill] = BODY_SYM[pick][i];
              stack_fill++;
            end
            add_event(EV_PROD, pick, '0);
            if (stack_fill == 0) restart_stack();
          end
        end else if (top > GS_TERM_HI) begin
          stack_fill--;
          add_event(EV_MARK, '0, '0);
          if (stack_fill == 0) restart_stack();
        end else if (int'(kind) < TK_VALID_COUNT && int'(top) == int'(kind) + int'(GS_TERM_LO)) begin
          stack_fill--;
          if (stack_fill == 0) begin
            // end of input matched against the bottom of the stack
            add_event(EV_ACCEPT, '0, value);
            restart_stack();
          end else begin
            add_event(EV_MATCH, '0, value);
          end
          done = 1'b1;
        end else begin
          add_event(EV_ERROR, '0, '0);
          restart_stack();
          done = 1'b1;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Script building
  // ---------------------------------------------------------------------------

  // Append one token with a random value; a pending mangle swaps in a random kind.
  task automatic add_token(input tkind_t kind);
    token_row_t row;
    row = '0;
    row.kind = kind;
    if (mangle_countdown == 0) row.kind = tkind_t'($urandom_range(0, 7));
    if (mangle_countdown >= 0) mangle_countdown--;
    case ($urandom_range(0, 7))
      0:       row.value = '0;
      1:       row.value = '1;
      default: row.value = tvalue_t'($urandom_range(0, 65535));
    endcase
    token_script.push_back(row);
  endtask

  // Well-formed expression of roughly target_len tokens, closed and ended with '$'.
  task automatic add_expression(input int unsigned target_len);
    int unsigned open_cnt;
    int unsigned emitted;
    bit          need_operand;
    open_cnt     = 0;
    emitted      = 0;
    need_operand = 1'b1;
    while (need_operand || open_cnt > 0 || emitted < target_len) begin
      if (need_operand) begin
        if (emitted < target_len && open_cnt < 6 && $urandom_range(0, 3) == 0) begin
          add_token(TK_LPAREN);
          open_cnt++;
        end else begin
          add_token(TK_DIGIT);
          need_operand = 1'b0;
        end
      end else if (open_cnt > 0 && (emitted >= target_len || $urandom_range(0, 3) == 0)) begin
        add_token(TK_RPAREN);
        open_cnt--;
      end else begin
        add_token($urandom_range(0, 1) ? TK_PLUS : TK_STAR);
        need_operand = 1'b1;
      end
      emitted++;
    end
    add_token(TK_END);
  endtask

  // Deep nesting; 21 or more open parens overflow a 64-entry stack.
  task automatic add_nested(input int unsigned depth);
    repeat (depth) add_token(TK_LPAREN);
    add_token(TK_DIGIT);
    repeat (depth) add_token(TK_RPAREN);
    add_token(TK_END);
  endtask

  // ---------------------------------------------------------------------------
  // Main flow: reset, build the script, drive tokens, drain, report
  // ---------------------------------------------------------------------------
  initial begin : main_flow
    token_row_t    row;
    directed_row_t drow;
    parse_event_t  ev;
    int unsigned   idx;
    int unsigned   burst_left;
    int unsigned   gap;
    int unsigned   pick;
    int unsigned   i;

    rst                  <= 1'b1;
    token_ch.valid       <= 1'b0;
    token_ch.token_kind  <= '0;
    token_ch.token_value <= '0;
    restart_stack();

    // Walk the directed table into the script.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      drow           = DIRECTED_TBL[i];
      row.kind       = drow.kind;
      row.value      = drow.value;
      row.typed      = drow.typed;
      row.want.kind  = drow.want_kind;
      row.want.prod  = drow.want_prod;
      row.want.value = drow.want_value;
      row.want.last  = 1'b1;
      token_script.push_back(row);
    end

    // Random part: mostly well-formed sentences, some broken ones, noise and deep
    // nesting. Open with one sentence that is sure to overflow the stack.
    add_nested(22);
    while (token_script.size() < DIRECTED_ROWS + RANDOM_TOKENS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        add_nested($urandom_range(16, 24));
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 4)) add_token(tkind_t'($urandom_range(0, 7)));
      end else begin
        if (pick <= 4) mangle_countdown = $urandom_range(0, 8);
        add_expression($urandom_range(1, 12));
        mangle_countdown = -1;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Send in bursts; hold valid and payload until the transaction is taken.
    idx        = 0;
    burst_left = 0;
    while (idx < token_script.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          token_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      row = token_script[idx];
      token_ch.valid       <= 1'b1;
      token_ch.token_kind  <= row.kind;
      token_ch.token_value <= row.value;
      @(posedge clk);
      while (!token_ch.ready) @(posedge clk);
      // Transaction taken at this edge: advance the predictor in step.
      predict_parse_events(row.kind, row.value);
      if (row.typed) begin
        expected_events.push_back(row.want);
      end else begin
        for (i = 0; i < token_events.size(); i++) begin
          ev      = token_events[i];
          ev.last = (i == token_events.size() - 1);
          expected_events.push_back(ev);
        end
      end
      tokens_sent++;
      idx++;
      burst_left--;
    end
    token_ch.valid <= 1'b0;

    // Drain; the watchdog catches events that never arrive.
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d tokens and checked %0d parse events: %0d accepts, %0d errors, %0d add markers.",
             tokens_sent, events_checked, accept_count, error_count, mark_count);
    $display("Stimulus included stack overflow by deep nesting and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Event receiver: random ready pattern, plus one long hold-off so the token
  // queue fills and the parser drops its input ready.
  // ---------------------------------------------------------------------------
  initial begin : event_sink
    int unsigned run_left;
    sink_mode_t  mode;
    bit          held;
    event_ch.ready <= 1'b0;
    run_left = 0;
    mode     = SINK_OPEN;
    held     = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && events_checked >= HOLD_AFTER) begin
        event_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = sink_mode_t'($urandom_range(0, 2));
          run_left = $urandom_range(4, 60);
        end
        case (mode)
          SINK_OPEN: event_ch.ready <= 1'b1;
          SINK_BUSY: event_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   event_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        run_left--;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each output transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : event_check
    parse_event_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_kind %0d with nothing pending", event_ch.event_kind);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_ch.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, event_ch.event_kind);
          fail_count++;
        end
        if (event_ch.production !== want.prod) begin
          $error("production: expected %0d, actual %0d", want.prod, event_ch.production);
          fail_count++;
        end
        if (event_ch.matched_value !== want.value) begin
          $error("matched_value: expected 0x%04h, actual 0x%04h", want.value,
                 event_ch.matched_value);
          fail_count++;
        end
        if (event_ch.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, event_ch.last);
          fail_count++;
        end
      end
      events_checked++;
      if (event_ch.event_kind == EV_ACCEPT) accept_count++;
      if (event_ch.event_kind == EV_ERROR)  error_count++;
      if (event_ch.event_kind == EV_MARK)   mark_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run after too many cycles with no transaction on either side.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (token_ch.valid && token_ch.ready) || (event_ch.valid && event_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timed out after %0d idle cycles with %0d events pending.", IDLE_LIMIT,
             expected_events.size());
    $display("FAIL");
    $finish;
  end

endmodule
